@@ rtl/ebra_pkg.sv @@
// Package: widths, request/result types and constants for the evacuation budget admission unit.
`timescale 1ns / 1ps
`default_nettype none

package ebra_pkg;

  localparam int BYTE_BITS = 44;
  localparam int REGION_W  = 26;
  localparam int ID_W      = 16;
  localparam int COUNT_W   = 16;
  localparam int RECIP_W   = 16;

  localparam logic [REGION_W-1:0] REGION_BYTES_MAX = REGION_W'(33554432);
  localparam logic [RECIP_W-1:0]  RECIP_RESET      = RECIP_W'(46811);
  localparam logic [COUNT_W-1:0]  COUNT_MAX        = {COUNT_W{1'b1}};
  localparam logic [BYTE_BITS-1:0] BYTE_MASK       = {BYTE_BITS{1'b1}};

  localparam int IN_FIELD_BITS  = 3 * BYTE_BITS + ID_W + 2 * REGION_W + 1;
  localparam int IN_TDATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = ID_W + 3 + COUNT_W + BYTE_BITS;
  localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic {
    REQ_BEGIN  = 1'b0,
    REQ_REGION = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [BYTE_BITS-1:0]  reserve_bytes;
    logic [BYTE_BITS-1:0]  unaffiliated_bytes;
    logic [BYTE_BITS-1:0]  available_bytes;
    logic [ID_W-1:0]       region_id;
    logic [REGION_W-1:0]   live_size;
    logic [REGION_W-1:0]   free_bytes;
    logic                  pinned_flag;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]       out_region_id;
    logic                  admitted;
    logic                  skipped_pinned;
    logic                  exhausted;
    logic [COUNT_W-1:0]    admitted_count;
    logic [BYTE_BITS-1:0]  evacuated_total;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/ebra_in_stage.sv @@
// Input register: unpacks the slave beat and holds it until the core consumes it.
`timescale 1ns / 1ps
`default_nettype none

module ebra_in_stage (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [ebra_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire                               s_axis_tuser,
  input  wire                               advance,
  output logic                              in_valid,
  output ebra_pkg::req_t                    req
);
  import ebra_pkg::*;

  localparam int OFF_UNAFF = BYTE_BITS;
  localparam int OFF_AVAIL = 2 * BYTE_BITS;
  localparam int OFF_ID    = 3 * BYTE_BITS;
  localparam int OFF_LIVE  = OFF_ID + ID_W;
  localparam int OFF_FREE  = OFF_LIVE + REGION_W;
  localparam int OFF_PIN   = OFF_FREE + REGION_W;

  req_t beat;

  always_comb begin
    beat.req_type           = req_type_t'(s_axis_tuser);
    beat.reserve_bytes      = s_axis_tdata[BYTE_BITS-1:0];
    beat.unaffiliated_bytes = s_axis_tdata[OFF_UNAFF +: BYTE_BITS];
    beat.available_bytes    = s_axis_tdata[OFF_AVAIL +: BYTE_BITS];
    beat.region_id          = s_axis_tdata[OFF_ID +: ID_W];
    beat.live_size          = s_axis_tdata[OFF_LIVE +: REGION_W];
    beat.free_bytes         = s_axis_tdata[OFF_FREE +: REGION_W];
    beat.pinned_flag        = s_axis_tdata[OFF_PIN];
  end

  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req <= beat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ebra_core.sv @@
// Budget core: pool state, waste reciprocal register and per-beat admission logic.
`timescale 1ns / 1ps
`default_nettype none

module ebra_core (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [ebra_pkg::RECIP_W-1:0]   cfg_wdata,
  input  wire                           advance,
  input  ebra_pkg::req_t                req,
  output ebra_pkg::result_t             res,
  output logic                          stopped
);
  import ebra_pkg::*;

  localparam int BPROD_W = BYTE_BITS + RECIP_W;
  localparam int LPROD_W = REGION_W + RECIP_W;

  logic [RECIP_W-1:0]   waste_reciprocal;
  logic [BYTE_BITS-1:0] unfrag_pool, frag_pool, excess_pool, bytes_admitted;
  logic [COUNT_W-1:0]   count_admitted;

  logic [BYTE_BITS-1:0] unfrag_pool_next, frag_pool_next, excess_pool_next;
  logic [BYTE_BITS-1:0] bytes_admitted_next;
  logic [COUNT_W-1:0]   count_admitted_next;
  logic                 stopped_next;

  logic [BPROD_W-1:0]   prod_b;
  logic [BYTE_BITS-1:0] budget, total;
  logic [REGION_W-1:0]  live_c, lost_c, lost_a, scaled, scaled_a;
  logic [LPROD_W-1:0]   prod_l;
  logic [REGION_W:0]    sum_sl;
  logic [BYTE_BITS-1:0] live_x, lost_x, excess_a, frag_a, frag_b, unfrag_a, need;
  logic                 fit;

  assign live_c = (req.live_size > REGION_BYTES_MAX) ? REGION_BYTES_MAX : req.live_size;
  assign lost_c = (req.free_bytes > REGION_BYTES_MAX) ? REGION_BYTES_MAX : req.free_bytes;
  assign live_x = BYTE_BITS'(live_c);
  assign lost_x = BYTE_BITS'(lost_c);

  assign prod_b = BPROD_W'(req.reserve_bytes) * BPROD_W'(waste_reciprocal);
  assign budget = prod_b[BPROD_W-1:RECIP_W];

  // lost space first eats the excess pool
  always_comb begin
    excess_a = excess_pool;
    lost_a   = lost_c;
    if (lost_c != '0 && excess_pool != '0) begin
      if (lost_x < excess_pool) begin
        excess_a = excess_pool - lost_x;
        lost_a   = '0;
      end else begin
        lost_a   = lost_c - excess_pool[REGION_W-1:0];
        excess_a = '0;
      end
    end
  end

  assign prod_l = LPROD_W'(lost_a) * LPROD_W'(waste_reciprocal);
  assign scaled = prod_l[LPROD_W-1:RECIP_W];
  assign sum_sl = (REGION_W+1)'(scaled) + (REGION_W+1)'(live_c);

  always_comb begin
    frag_a   = frag_pool;
    scaled_a = scaled;
    if (lost_a != '0 && frag_pool != '0 && BYTE_BITS'(sum_sl) < frag_pool) begin
      frag_a   = frag_pool - BYTE_BITS'(scaled);
      scaled_a = '0;
    end
    frag_b = frag_a;
    need   = '0;
    if (scaled_a != '0) begin
      fit      = (live_x <= unfrag_pool);
      unfrag_a = unfrag_pool - live_x;
    end else begin
      if (live_x > frag_a) begin
        need   = live_x - frag_a;
        frag_b = '0;
      end else begin
        frag_b = frag_a - live_x;
      end
      fit      = (need <= unfrag_pool);
      unfrag_a = unfrag_pool - need;
    end
  end

  always_comb begin
    unfrag_pool_next    = unfrag_pool;
    frag_pool_next      = frag_pool;
    excess_pool_next    = excess_pool;
    stopped_next        = stopped;
    count_admitted_next = count_admitted;
    bytes_admitted_next = bytes_admitted;
    total               = '0;
    res.out_region_id   = req.region_id;
    res.admitted        = 1'b0;
    res.skipped_pinned  = 1'b0;
    res.exhausted       = 1'b0;
    if (req.req_type == REQ_BEGIN) begin
      unfrag_pool_next = req.unaffiliated_bytes;
      frag_pool_next   = '0;
      excess_pool_next = '0;
      if (req.unaffiliated_bytes > budget) begin
        unfrag_pool_next = budget;
      end else begin
        total = (req.available_bytes > req.unaffiliated_bytes) ?
                req.available_bytes : req.unaffiliated_bytes;
        frag_pool_next = total - req.unaffiliated_bytes;
        if (total > budget) begin
          excess_pool_next = total - budget;
          frag_pool_next   = budget - req.unaffiliated_bytes;
        end
      end
      stopped_next        = 1'b0;
      count_admitted_next = '0;
      bytes_admitted_next = '0;
    end else if (stopped) begin
      res.exhausted = 1'b1;
    end else if (req.pinned_flag) begin
      res.skipped_pinned = 1'b1;
    end else begin
      excess_pool_next = excess_a;
      frag_pool_next   = frag_b;
      if (fit) begin
        unfrag_pool_next = unfrag_a;
        res.admitted     = 1'b1;
        if (count_admitted != COUNT_MAX) begin
          count_admitted_next = count_admitted + 1'b1;
        end
        if (live_x > BYTE_MASK - bytes_admitted) begin
          bytes_admitted_next = BYTE_MASK;
        end else begin
          bytes_admitted_next = bytes_admitted + live_x;
        end
      end else begin
        stopped_next  = 1'b1;
        res.exhausted = 1'b1;
      end
    end
    res.admitted_count  = count_admitted_next;
    res.evacuated_total = bytes_admitted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waste_reciprocal <= RECIP_RESET;
    end else if (cfg_we) begin
      waste_reciprocal <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unfrag_pool    <= '0;
      frag_pool      <= '0;
      excess_pool    <= '0;
      stopped        <= 1'b1;
      count_admitted <= '0;
      bytes_admitted <= '0;
    end else if (advance) begin
      unfrag_pool    <= unfrag_pool_next;
      frag_pool      <= frag_pool_next;
      excess_pool    <= excess_pool_next;
      stopped        <= stopped_next;
      count_admitted <= count_admitted_next;
      bytes_admitted <= bytes_admitted_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ebra_out_stage.sv @@
// Output register: holds one result beat and packs it onto the master side.
`timescale 1ns / 1ps
`default_nettype none

module ebra_out_stage (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               load,
  input  ebra_pkg::result_t                 res,
  output logic                              can_take,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [ebra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import ebra_pkg::*;

  result_t held;

  assign can_take = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (can_take) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_take) begin
      held <= res;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({held.evacuated_total, held.admitted_count,
                                      held.exhausted, held.skipped_pinned,
                                      held.admitted, held.out_region_id});

endmodule

`default_nettype wire

@@ rtl/evac_budget_region_admission_unit.sv @@
// Top level of the evacuation budget and region admission unit.
`timescale 1ns / 1ps
`default_nettype none

// One beat is taken per clock cycle while the master side accepts results, and
// every beat yields exactly one result beat. The input register takes the beat
// when it is accepted, and the result register loads its result from the input
// register once the output register is free to take it.
// A begin beat splits the reserve, scaled by the Q0.16 waste reciprocal, into
// unfragmented, fragmented and excess pools; region beats that follow are
// admitted, skipped as pinned or refused, and the first refusal ends the pass
// until the next begin. The one-cycle rate is set by the pool update loop:
// the reciprocal multiply, the excess and fragmented charges and the pool
// compares are combinational between the pool registers. The waste reciprocal
// may be written only while no beat is in flight. Backpressure on the master
// side stalls the slave side through the two register stages with no loss.
module evac_budget_region_admission_unit (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [ebra_pkg::RECIP_W-1:0]       cfg_wdata,
  // s_axis_tdata, low bit up: reserve_bytes, unaffiliated_bytes, available_bytes,
  // region_id, live_size, free_bytes, pinned_flag, zero fill
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [ebra_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // s_axis_tuser: req_type
  input  wire                               s_axis_tuser,
  // m_axis_tdata, low bit up: out_region_id, admitted, skipped_pinned, exhausted,
  // admitted_count, evacuated_total, zero fill
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [ebra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import ebra_pkg::*;

  logic    in_valid;
  req_t    req;
  result_t res;
  logic    can_take;
  logic    advance;
  logic    stopped;

  assign advance = in_valid && can_take;

  ebra_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance       (advance),
    .in_valid      (in_valid),
    .req           (req)
  );

  ebra_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .req       (req),
    .res       (res),
    .stopped   (stopped)
  );

  ebra_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .res           (res),
    .can_take      (can_take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    advance |-> $onehot0({res.admitted, res.skipped_pinned, res.exhausted}))
    else $error("more than one outcome flag set");

  a_begin_opens: assert property (@(posedge clk) disable iff (rst)
    (advance && req.req_type == REQ_BEGIN) |=> !stopped)
    else $error("begin beat did not open a pass");

  a_refusal_stops: assert property (@(posedge clk) disable iff (rst)
    (advance && res.exhausted) |=> stopped)
    else $error("exhausted result left the pass open");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (advance && res.admitted) |-> (res.admitted_count != '0))
    else $error("admitted region with zero count");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("empty input register not ready");

endmodule

`default_nettype wire
